@@ rtl/srde_pkg.sv @@
// Shared types and constants for the signed radix digit emitter.
// No dependencies; used by srde_divider and signed_radix_digit_emitter.
`timescale 1ns / 1ps

package srde_pkg;

  localparam int CHAR_W    = 8;
  localparam int SYM_IDX_W = 6;
  localparam int CFG_W     = 7;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_SCAN_RD   = 12'b0000_0000_0010,
    ST_SCAN_CK   = 12'b0000_0000_0100,
    ST_DUP_RD    = 12'b0000_0000_1000,
    ST_DUP_CK    = 12'b0000_0001_0000,
    ST_DIV_GO    = 12'b0000_0010_0000,
    ST_DIV_WAIT  = 12'b0000_0100_0000,
    ST_LOOK_RD   = 12'b0000_1000_0000,
    ST_LOOK_WR   = 12'b0001_0000_0000,
    ST_EMIT_SIGN = 12'b0010_0000_0000,
    ST_EMIT_RD   = 12'b0100_0000_0000,
    ST_EMIT_OUT  = 12'b1000_0000_0000
  } state_t;

endpackage

@@ rtl/srde_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on srde_pkg (div_stat_t).
`timescale 1ns / 1ps

module srde_divider #(
  parameter int VALUE_BITS = 32,
  parameter int RADIX_BITS = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_BITS-1:0] divisor,
  output srde_pkg::div_stat_t   stat,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [RADIX_BITS-1:0] remainder
);

  localparam int CW = $clog2(VALUE_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [RADIX_BITS-1:0] rem_r, rem_nxt;
  logic [RADIX_BITS-1:0] dvs_r, dvs_nxt;
  logic [RADIX_BITS:0]   trial;
  logic [RADIX_BITS:0]   diff;
  logic                  fits;

  assign trial = {rem_r, q_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VALUE_BITS - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[VALUE_BITS-2:0], fits};
      rem_nxt = fits ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

@@ rtl/signed_radix_digit_emitter.sv @@
// Top level: converts a signed integer to digit characters of a loaded symbol base.
// Depends on srde_pkg and srde_divider.
`timescale 1ns / 1ps

//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+--------------------------
//  input   | in_command in_symbol_index in_symbol_char in_value | start && !busy
//  result  | out_char out_last                                  | out_valid, one cycle each
//  config  | cfg_base_length                                    | cfg_valid && cfg_ready
//
// A load word writes one table entry; busy stays low. A convert word first scans
// the base (L = base length checked), then checks every pair of symbols for
// duplicates on the two table read ports, then runs the bit-serial divider once
// per digit, then emits the sign, if negative, and the digits on output.
// Synchronous active-low reset clears control state; the table is undefined until
// loaded. The receiver cannot stall: each word is shown for exactly one cycle.

module signed_radix_digit_emitter #(
  parameter int MAX_SYMBOLS = 64,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_command,
  input  logic [srde_pkg::SYM_IDX_W-1:0]        in_symbol_index,
  input  logic [srde_pkg::CHAR_W-1:0]           in_symbol_char,
  input  logic signed [VALUE_BITS-1:0]          in_value,
  // result channel
  output logic                                  out_valid,
  output logic [srde_pkg::CHAR_W-1:0]           out_char,
  output logic                                  out_last,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [srde_pkg::CFG_W-1:0]            cfg_base_length
);

  localparam int IW  = $clog2(MAX_SYMBOLS);         // table address
  localparam int LW  = $clog2(MAX_SYMBOLS + 1);     // length / radix
  localparam int AXW = (IW > srde_pkg::SYM_IDX_W) ? IW : srde_pkg::SYM_IDX_W;
  localparam int DW  = $clog2(VALUE_BITS);          // digit buffer address
  localparam int NW  = $clog2(VALUE_BITS + 1);      // digit count
  localparam int CW  = srde_pkg::CHAR_W;

  srde_pkg::state_t state_r, state_nxt;

  logic [srde_pkg::CFG_W-1:0] base_len_r;
  logic [LW-1:0]              cap_r, cap_nxt;
  logic [LW-1:0]              n_r, n_nxt;       // scan count, then radix
  logic [LW-1:0]              i_r, i_nxt;
  logic [LW-1:0]              j_r, j_nxt;
  logic                       neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]      mag_r, mag_nxt;
  logic [NW-1:0]              nd_r, nd_nxt;     // digits stored so far
  logic [NW-1:0]              k_r, k_nxt;       // emit pointer

  logic                       out_valid_r, out_valid_nxt;
  logic [CW-1:0]              out_char_r, out_char_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       accept;
  logic [AXW-1:0]             ld_idx;
  logic                       tab_we;
  logic [IW-1:0]              addr_a;
  logic [IW-1:0]              addr_b;
  logic [CW-1:0]              rd_a_r;
  logic [CW-1:0]              rd_b_r;
  logic [CW-1:0]              tab_mem [MAX_SYMBOLS];

  logic                       dig_we;
  logic [CW-1:0]              dig_rd_r;
  logic [CW-1:0]              dig_mem [VALUE_BITS];

  logic                       div_start;
  srde_pkg::div_stat_t        div_stat;
  logic [VALUE_BITS-1:0]      div_quo;
  logic [LW-1:0]              div_rem;

  assign accept    = start && !busy;
  assign busy      = (state_r != srde_pkg::ST_IDLE);
  assign cfg_ready = (state_r == srde_pkg::ST_IDLE);
  assign ld_idx    = AXW'(in_symbol_index);

  // loads ignore positions past the table depth
  assign tab_we = accept && (in_command == srde_pkg::CMD_LOAD) &&
                  (32'(in_symbol_index) < MAX_SYMBOLS);

  // symbol table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[ld_idx[IW-1:0]] <= in_symbol_char;
    end
    rd_a_r <= tab_mem[addr_a];
    rd_b_r <= tab_mem[addr_b];
  end

  // digit buffer, least significant digit at address 0
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[nd_r[DW-1:0]] <= rd_a_r;
    end
    dig_rd_r <= dig_mem[k_r[DW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_len_r <= cfg_base_length;
    end
  end

  srde_divider #(
    .VALUE_BITS (VALUE_BITS),
    .RADIX_BITS (LW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (n_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // port A: scan position, first symbol of a pair, or remainder lookup
  always_comb begin
    case (state_r)
      srde_pkg::ST_SCAN_RD: addr_a = n_r[IW-1:0];
      srde_pkg::ST_LOOK_RD: addr_a = div_rem[IW-1:0];
      default:              addr_a = i_r[IW-1:0];
    endcase
  end
  assign addr_b = j_r[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    nd_nxt        = nd_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    dig_we        = 1'b0;

    case (state_r)
      srde_pkg::ST_IDLE: begin
        if (accept && (in_command == srde_pkg::CMD_CONVERT)) begin
          if (32'(base_len_r) < MAX_SYMBOLS) begin
            cap_nxt = LW'(base_len_r);
          end else begin
            cap_nxt = LW'(MAX_SYMBOLS);
          end
          n_nxt   = '0;
          neg_nxt = in_value[VALUE_BITS-1];
          // unsigned magnitude; the most negative value maps to 2^(N-1)
          mag_nxt = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
          nd_nxt  = '0;
          state_nxt = srde_pkg::ST_SCAN_RD;
        end
      end

      srde_pkg::ST_SCAN_RD: begin
        if (n_r == cap_r) begin
          if (n_r < LW'(2)) begin
            state_nxt = srde_pkg::ST_IDLE;       // base too short
          end else begin
            i_nxt     = '0;
            j_nxt     = LW'(1);
            state_nxt = srde_pkg::ST_DUP_RD;
          end
        end else begin
          state_nxt = srde_pkg::ST_SCAN_CK;
        end
      end

      srde_pkg::ST_SCAN_CK: begin
        if (rd_a_r == srde_pkg::CHAR_NUL) begin
          cap_nxt   = n_r;                     // base ends at the zero byte
          state_nxt = srde_pkg::ST_SCAN_RD;
        end else if (rd_a_r == srde_pkg::CHAR_PLUS || rd_a_r == srde_pkg::CHAR_MINUS) begin
          state_nxt = srde_pkg::ST_IDLE;
        end else begin
          n_nxt     = n_r + LW'(1);
          state_nxt = srde_pkg::ST_SCAN_RD;
        end
      end

      srde_pkg::ST_DUP_RD: begin
        state_nxt = srde_pkg::ST_DUP_CK;
      end

      srde_pkg::ST_DUP_CK: begin
        if (rd_a_r == rd_b_r) begin
          state_nxt = srde_pkg::ST_IDLE;
        end else if (j_r == n_r - LW'(1)) begin
          if (i_r == n_r - LW'(2)) begin
            state_nxt = srde_pkg::ST_DIV_GO;
          end else begin
            i_nxt     = i_r + LW'(1);
            j_nxt     = i_r + LW'(2);
            state_nxt = srde_pkg::ST_DUP_RD;
          end
        end else begin
          j_nxt     = j_r + LW'(1);
          state_nxt = srde_pkg::ST_DUP_RD;
        end
      end

      srde_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = srde_pkg::ST_DIV_WAIT;
      end

      srde_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = srde_pkg::ST_LOOK_RD;
        end
      end

      srde_pkg::ST_LOOK_RD: begin
        state_nxt = srde_pkg::ST_LOOK_WR;
      end

      srde_pkg::ST_LOOK_WR: begin
        dig_we  = 1'b1;
        nd_nxt  = nd_r + NW'(1);
        mag_nxt = div_quo;
        if (div_quo == '0) begin
          k_nxt     = nd_r;                    // most significant digit
          state_nxt = neg_r ? srde_pkg::ST_EMIT_SIGN : srde_pkg::ST_EMIT_RD;
        end else begin
          state_nxt = srde_pkg::ST_DIV_GO;
        end
      end

      srde_pkg::ST_EMIT_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = srde_pkg::CHAR_MINUS;
        out_last_nxt  = 1'b0;
        state_nxt     = srde_pkg::ST_EMIT_RD;
      end

      srde_pkg::ST_EMIT_RD: begin
        state_nxt = srde_pkg::ST_EMIT_OUT;
      end

      srde_pkg::ST_EMIT_OUT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = dig_rd_r;
        out_last_nxt  = (k_r == '0);
        if (k_r == '0) begin
          state_nxt = srde_pkg::ST_IDLE;
        end else begin
          k_nxt     = k_r - NW'(1);
          state_nxt = srde_pkg::ST_EMIT_RD;
        end
      end

      default: begin
        state_nxt = srde_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srde_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
    end
    cap_r      <= cap_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    k_r        <= k_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  // a word only leaves from one of the two emit states
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == srde_pkg::ST_EMIT_SIGN ||
                     $past(state_r) == srde_pkg::ST_EMIT_OUT))
    else $error("result word without an emit state");

  // the final character closes the conversion
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == srde_pkg::ST_IDLE))
    else $error("last character while conversion still running");

  // digit buffer never overflows
  a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nd_r) <= VALUE_BITS)
    else $error("digit count past buffer depth");

  // divider is only kicked when free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // an accepted convert word always enters the base scan
  a_conv_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == srde_pkg::CMD_CONVERT) |=> (state_r == srde_pkg::ST_SCAN_RD))
    else $error("convert word not started");
`endif

endmodule
